/* rtl/fpp_pkg.sv */
// ----------------------------------------------------------------------------
// fpp_pkg
// Shared widths, codes and the cell control word for fixed partition
// placement.
// ----------------------------------------------------------------------------
package fpp_pkg;

  localparam int MAX_PARTITIONS_DEF = 16;
  localparam int SIZE_BITS_DEF      = 16;

  localparam int CMD_W    = 2;
  localparam int PIDX_W   = 4;
  localparam int STAT_W   = 2;
  localparam int POLICY_W = 2;
  localparam int CNT_W    = 5;
  localparam int PADDR_W  = 3;
  localparam int PDATA_W  = 32;

  localparam logic [CMD_W-1:0] CMD_LOAD  = 2'd0;
  localparam logic [CMD_W-1:0] CMD_ALLOC = 2'd1;
  localparam logic [CMD_W-1:0] CMD_CLEAR = 2'd2;

  localparam logic [POLICY_W-1:0] FIT_FIRST = 2'd0;
  localparam logic [POLICY_W-1:0] FIT_BEST  = 2'd1;
  localparam logic [POLICY_W-1:0] FIT_WORST = 2'd2;
  localparam logic [POLICY_W-1:0] FIT_NEXT  = 2'd3;

  localparam logic [STAT_W-1:0] STAT_DONE  = 2'd0;
  localparam logic [STAT_W-1:0] STAT_ALLOC = 2'd1;
  localparam logic [STAT_W-1:0] STAT_NOFIT = 2'd2;

  // Register select is address bit 2 (registers at byte 0 and 4).
  localparam logic REG_FIT_POLICY = 1'b0;
  localparam logic REG_PART_COUNT = 1'b1;

  localparam logic [POLICY_W-1:0] POLICY_RESET = FIT_FIRST;
  localparam logic [CNT_W-1:0]    COUNT_RESET  = 5'd16;

  // Broadcast control seen by every cell.
  typedef struct packed {
    logic                load;
    logic                clear;
    logic                mark;
    logic [POLICY_W-1:0] policy;
  } cell_ctrl_t;

endpackage

/* rtl/fpp_if.sv */
// ----------------------------------------------------------------------------
// fpp_if
// Request and response channels of fixed partition placement.
// ----------------------------------------------------------------------------
interface fpp_req_if #(
  parameter int SIZE_BITS = 16
) ();
  import fpp_pkg::*;

  logic                 valid;
  logic                 ready;
  logic [CMD_W-1:0]     command;
  logic [PIDX_W-1:0]    partition_index;
  logic [SIZE_BITS-1:0] size_value;

  modport source (output valid, command, partition_index, size_value, input ready);
  modport sink   (input valid, command, partition_index, size_value, output ready);
endinterface

interface fpp_rsp_if #(
  parameter int SIZE_BITS = 16
) ();
  import fpp_pkg::*;

  logic                 valid;
  logic                 ready;
  logic [STAT_W-1:0]    status;
  logic [PIDX_W-1:0]    granted_index;
  logic [SIZE_BITS-1:0] granted_size;

  modport source (output valid, status, granted_index, granted_size, input ready);
  modport sink   (input valid, status, granted_index, granted_size, output ready);
endinterface

/* rtl/fpp_cell.sv */
// ----------------------------------------------------------------------------
// fpp_cell
// One partition: holds its size and used mark, and updates the search
// candidate as the search token passes through.
// ----------------------------------------------------------------------------
module fpp_cell #(
  parameter int CELL_INDEX = 0,
  parameter int IDX_W      = 4,
  parameter int SIZE_BITS  = 16
) (
  input  logic                         clk,
  input  logic                         rst,
  input  fpp_pkg::cell_ctrl_t          ctrl,
  input  logic [fpp_pkg::PIDX_W-1:0]   load_index,
  input  logic [SIZE_BITS-1:0]         load_size,
  input  logic [IDX_W-1:0]             mark_index,
  input  logic [SIZE_BITS-1:0]         req_size,
  input  logic [fpp_pkg::CNT_W-1:0]    count,
  input  logic [IDX_W-1:0]             nf_start,
  input  logic                         tok_in,
  input  logic                         found_in,
  input  logic [IDX_W-1:0]             idx_in,
  input  logic [SIZE_BITS-1:0]         size_in,
  input  logic                         nf_found_in,
  input  logic [IDX_W-1:0]             nf_idx_in,
  input  logic [SIZE_BITS-1:0]         nf_size_in,
  output logic                         tok_out,
  output logic                         found_out,
  output logic [IDX_W-1:0]             idx_out,
  output logic [SIZE_BITS-1:0]         size_out,
  output logic                         nf_found_out,
  output logic [IDX_W-1:0]             nf_idx_out,
  output logic [SIZE_BITS-1:0]         nf_size_out,
  output logic                         used_out
);
  import fpp_pkg::*;

  localparam int LW = (IDX_W > PIDX_W) ? IDX_W : PIDX_W;
  localparam int CW = (IDX_W + 1 > CNT_W) ? IDX_W + 1 : CNT_W;
  localparam logic [IDX_W-1:0] MY_IDX = IDX_W'(CELL_INDEX);

  logic [SIZE_BITS-1:0] size;
  logic                 used;
  logic                 active;
  logic                 fits;
  logic                 better;
  logic                 take;
  logic                 take_nf;

  assign active  = CW'(count) > CW'(CELL_INDEX);
  assign fits    = active && !used && (size >= req_size);
  assign better  = ((ctrl.policy == FIT_BEST)  && (size < size_in)) ||
                   ((ctrl.policy == FIT_WORST) && (size > size_in));
  assign take    = fits && (!found_in || better);
  // next fit: first free entry at or after the start point
  assign take_nf = fits && (MY_IDX >= nf_start) && !nf_found_in;

  always_ff @(posedge clk) begin
    if (rst) begin
      used <= 1'b0;
    end else if (ctrl.clear) begin
      used <= 1'b0;
    end else if (ctrl.load && (LW'(load_index) == LW'(CELL_INDEX))) begin
      used <= 1'b0;
    end else if (ctrl.mark && (mark_index == MY_IDX)) begin
      used <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.load && (LW'(load_index) == LW'(CELL_INDEX))) begin
      size <= load_size;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      tok_out <= 1'b0;
    end else begin
      tok_out <= tok_in;
    end
  end

  always_ff @(posedge clk) begin
    found_out    <= found_in | take;
    idx_out      <= take ? MY_IDX : idx_in;
    size_out     <= take ? size : size_in;
    nf_found_out <= nf_found_in | take_nf;
    nf_idx_out   <= take_nf ? MY_IDX : nf_idx_in;
    nf_size_out  <= take_nf ? size : nf_size_in;
  end

  assign used_out = used;

endmodule

/* rtl/fixed_partition_placement.sv */
// ----------------------------------------------------------------------------
// fixed_partition_placement
// Fixed partition table with first, best, worst and next fit allocation.
// ----------------------------------------------------------------------------
// Usage: commands arrive as words on req (load size, allocate, free all);
// one result word per command leaves on rsp. fit_policy and
// partition_count are written over the APB port; the user must do so
// only while the block is idle, which the block does not enforce.
// Partitions sit in a chain of MAX_PARTITIONS cells. A load or free all
// answers in the cycle after acceptance. An allocate sends a search
// token down the chain, one cell per cycle, and answers after it leaves
// the last cell; the next command is taken at the same edge that reads
// the result, and loads run every cycle while rsp.ready is held high.
// One command is in flight at a time; req.ready is low while a search
// runs or while an unread result waits on rsp, so a stalled receiver
// holds off new commands and no word is dropped.
// Reset frees every partition, sets the next-fit pointer to zero, policy
// to first fit and the count to 16; sizes read as undefined until loaded.
// ----------------------------------------------------------------------------
module fixed_partition_placement #(
  parameter int MAX_PARTITIONS = fpp_pkg::MAX_PARTITIONS_DEF,
  parameter int SIZE_BITS      = fpp_pkg::SIZE_BITS_DEF
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [fpp_pkg::PADDR_W-1:0]  paddr,
  input  logic [fpp_pkg::PDATA_W-1:0]  pwdata,
  output logic [fpp_pkg::PDATA_W-1:0]  prdata,
  output logic                         pready,
  fpp_req_if.sink                      req,
  fpp_rsp_if.source                    rsp
);
  import fpp_pkg::*;

  localparam int IDX_W = (MAX_PARTITIONS > 1) ? $clog2(MAX_PARTITIONS) : 1;
  localparam int CW    = (IDX_W + 1 > CNT_W) ? IDX_W + 1 : CNT_W;

  localparam logic ST_IDLE = 1'b0;
  localparam logic ST_SCAN = 1'b1;

  logic                 state;
  logic [POLICY_W-1:0]  policy;
  logic [CNT_W-1:0]     count;
  logic [IDX_W-1:0]     nf_start;
  logic [IDX_W-1:0]     nf_start_eff;
  logic [SIZE_BITS-1:0] req_size;
  logic                 tok_start;
  logic                 accept;
  logic                 launch;
  logic                 cfg_wr;
  logic                 exit_tok;
  logic                 pick_found;
  logic                 pick_nf;
  logic [IDX_W-1:0]     pick_idx;
  logic [SIZE_BITS-1:0] pick_size;
  cell_ctrl_t           ctrl;

  logic                 tok_v    [0:MAX_PARTITIONS];
  logic                 found_v  [0:MAX_PARTITIONS];
  logic [IDX_W-1:0]     idx_v    [0:MAX_PARTITIONS];
  logic [SIZE_BITS-1:0] size_v   [0:MAX_PARTITIONS];
  logic                 nff_v    [0:MAX_PARTITIONS];
  logic [IDX_W-1:0]     nfi_v    [0:MAX_PARTITIONS];
  logic [SIZE_BITS-1:0] nfs_v    [0:MAX_PARTITIONS];
  logic [MAX_PARTITIONS-1:0] used_vec;
  logic [MAX_PARTITIONS-1:0] tok_vec;

  // Configuration port
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;

  always_comb begin
    unique case (paddr[2])
      REG_FIT_POLICY: prdata = PDATA_W'(policy);
      REG_PART_COUNT: prdata = PDATA_W'(count);
      default:        prdata = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      policy <= POLICY_RESET;
      count  <= COUNT_RESET;
    end else if (cfg_wr) begin
      unique case (paddr[2])
        REG_FIT_POLICY: policy <= pwdata[POLICY_W-1:0];
        REG_PART_COUNT: count  <= pwdata[CNT_W-1:0];
        default: ;
      endcase
    end
  end

  // Command handling
  assign req.ready = (state == ST_IDLE) && (!rsp.valid || rsp.ready);
  assign accept    = req.valid && req.ready;
  assign launch    = accept && (req.command == CMD_ALLOC);
  assign exit_tok  = tok_v[MAX_PARTITIONS];

  // stale pointer: restart the circular scan at zero
  assign nf_start_eff = (CW'(nf_start) < CW'(count)) ? nf_start : '0;

  assign pick_nf    = (policy == FIT_NEXT) && nff_v[MAX_PARTITIONS];
  assign pick_found = pick_nf || found_v[MAX_PARTITIONS];
  assign pick_idx   = pick_nf ? nfi_v[MAX_PARTITIONS] : idx_v[MAX_PARTITIONS];
  assign pick_size  = pick_nf ? nfs_v[MAX_PARTITIONS] : size_v[MAX_PARTITIONS];

  assign ctrl.load   = accept && (req.command == CMD_LOAD);
  assign ctrl.clear  = accept && (req.command == CMD_CLEAR);
  assign ctrl.mark   = exit_tok && pick_found;
  assign ctrl.policy = policy;

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      tok_start <= 1'b0;
      nf_start  <= '0;
    end else begin
      tok_start <= launch;
      unique case (state)
        ST_IDLE: if (launch) begin
          state <= ST_SCAN;
        end
        ST_SCAN: if (exit_tok) begin
          state <= ST_IDLE;
        end
        default: state <= ST_IDLE;
      endcase
      if (ctrl.clear) begin
        nf_start <= '0;
      end else if (ctrl.mark && (policy == FIT_NEXT)) begin
        nf_start <= pick_idx;
      end
    end
  end

  // Hold the request size for the whole walk
  always_ff @(posedge clk) begin
    if (launch) begin
      req_size <= req.size_value;
    end
  end

  // Result word
  always_ff @(posedge clk) begin
    if (rst) begin
      rsp.valid <= 1'b0;
    end else if (exit_tok || accept && !launch) begin
      rsp.valid <= 1'b1;
    end else if (rsp.ready) begin
      rsp.valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (exit_tok) begin
      rsp.status        <= pick_found ? STAT_ALLOC : STAT_NOFIT;
      rsp.granted_index <= pick_found ? PIDX_W'(pick_idx) : '0;
      rsp.granted_size  <= pick_found ? pick_size : '0;
    end else if (accept && !launch) begin
      rsp.status        <= STAT_DONE;
      rsp.granted_index <= '0;
      rsp.granted_size  <= '0;
    end
  end

  // Cell chain
  assign tok_v[0]   = tok_start;
  assign found_v[0] = 1'b0;
  assign idx_v[0]   = '0;
  assign size_v[0]  = '0;
  assign nff_v[0]   = 1'b0;
  assign nfi_v[0]   = '0;
  assign nfs_v[0]   = '0;

  for (genvar i = 0; i < MAX_PARTITIONS; i++) begin : g_cell
    fpp_cell #(
      .CELL_INDEX (i),
      .IDX_W      (IDX_W),
      .SIZE_BITS  (SIZE_BITS)
    ) u_cell (
      .clk          (clk),
      .rst          (rst),
      .ctrl         (ctrl),
      .load_index   (req.partition_index),
      .load_size    (req.size_value),
      .mark_index   (pick_idx),
      .req_size     (req_size),
      .count        (count),
      .nf_start     (nf_start_eff),
      .tok_in       (tok_v[i]),
      .found_in     (found_v[i]),
      .idx_in       (idx_v[i]),
      .size_in      (size_v[i]),
      .nf_found_in  (nff_v[i]),
      .nf_idx_in    (nfi_v[i]),
      .nf_size_in   (nfs_v[i]),
      .tok_out      (tok_v[i+1]),
      .found_out    (found_v[i+1]),
      .idx_out      (idx_v[i+1]),
      .size_out     (size_v[i+1]),
      .nf_found_out (nff_v[i+1]),
      .nf_idx_out   (nfi_v[i+1]),
      .nf_size_out  (nfs_v[i+1]),
      .used_out     (used_vec[i])
    );
    assign tok_vec[i] = tok_v[i+1];
  end

`ifndef NO_ASSERTIONS
  a_one_token: assert property (@(posedge clk) disable iff (rst)
    $onehot0({tok_start, tok_vec}))
    else $error("more than one search token in the chain");

  a_launch_walk: assert property (@(posedge clk) disable iff (rst)
    launch |=> tok_start && (state == ST_SCAN))
    else $error("allocate accepted without starting a search");

  a_pick_free: assert property (@(posedge clk) disable iff (rst)
    (exit_tok && pick_found) |-> !used_vec[pick_idx])
    else $error("search picked a partition already in use");

  a_mark_after: assert property (@(posedge clk) disable iff (rst)
    (exit_tok && pick_found) |=> used_vec[$past(pick_idx)])
    else $error("granted partition not marked used");

  a_zero_fields: assert property (@(posedge clk) disable iff (rst)
    (rsp.valid && (rsp.status != STAT_ALLOC)) |->
      (rsp.granted_index == '0) && (rsp.granted_size == '0))
    else $error("nonzero grant fields without an allocation");
`endif

endmodule
